// ===== rtl/ohash_pkg.sv =====
package ohash_pkg;

  localparam int CAPACITY = 1024;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_H1,
    S_H2,
    S_H3,
    S_H4,
    S_H5,
    S_H6,
    S_H7,
    S_HOME,
    S_READ,
    S_CHECK,
    S_OUT
  } state_t;

  localparam logic [0:0] CFG_SEED  = 1'b0;
  localparam logic [0:0] CFG_LIMIT = 1'b1;

  localparam logic [31:0] SEED_RESET  = 32'hdeadbeef;
  localparam logic [10:0] LIMIT_RESET = 11'd682;
  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] C3 = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== rtl/ohash_ram.sv =====
module ohash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ohash_hash.sv =====
module ohash_hash (
  input  logic        clk,
  input  logic [2:0]  step,
  input  logic [63:0] key,
  input  logic [31:0] seed,
  output logic [31:0] hash
);
  import ohash_pkg::*;

  logic [31:0] h_r, k_r;
  logic [31:0] h_nxt, k_nxt, hm;

  always_comb begin
    h_nxt = h_r;
    k_nxt = k_r;
    hm    = rotl(h_r ^ k_r, 13);
    case (step)
      3'd0: begin
        h_nxt = seed;
        k_nxt = key[31:0] * C1;
      end
      3'd1: k_nxt = rotl(k_r, 15) * C2;
      3'd2: begin
        h_nxt = (hm << 2) + hm + C3;
        k_nxt = key[63:32] * C1;
      end
      3'd3: k_nxt = rotl(k_r, 15) * C2;
      3'd4: begin
        h_nxt = (hm << 2) + hm + C3;
        h_nxt = h_nxt ^ 32'd8;
        h_nxt = h_nxt ^ (h_nxt >> 16);
        h_nxt = h_nxt * F1;
      end
      3'd5: h_nxt = (h_r ^ (h_r >> 13)) * F2;
      3'd6: h_nxt = h_r ^ (h_r >> 16);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    k_r <= k_nxt;
  end

  assign hash = h_r;
endmodule

// ===== rtl/open_addressing_hash_table.sv =====
// Linear-probing key/value table. After reset the block clears its whole tag
// memory and stalls its input meanwhile. Each transaction then hashes the key
// in states S_H1 to S_H7 with at most one 32-bit multiply per cycle, takes the
// home slot in S_HOME, then, unless the command is CMD_NONE or an insert over
// the fill limit, probes each slot by a memory read (S_READ) and a compare
// (S_CHECK). Results wait in S_OUT until taken; new input is taken in S_IDLE.
module open_addressing_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key,
  input  logic signed [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [63:0] out_found_value,
  output logic [9:0]  out_slot_index,
  output logic [10:0] out_live_count,
  output logic [31:0] out_collision_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ohash_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int NW = AW + 1;

  state_t state_r, state_nxt;
  logic [31:0] seed_r, coll_r;
  logic [10:0] limit_r, cnt_r;
  logic [2:0]  step_r;
  logic [1:0]  cmd_r;
  logic [63:0] key_r, val_r;
  logic [AW-1:0] idx_r, home_r;
  logic [NW-1:0] n_r;
  logic [31:0] hash;
  logic [1:0]  st_r;
  logic [63:0] fv_r;
  logic [9:0]  slot_r;

  logic          tag_we, kv_we;
  logic [AW-1:0] tag_wa;
  logic [1:0]    tag_wd, tag_rd;
  logic [63:0]   key_rd, val_rd;
  logic [AW-1:0] next_idx;
  logic          last;

  ohash_hash u_hash (.clk(clk), .step(step_r), .key(key_r), .seed(seed_r), .hash(hash));

  ohash_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
    .raddr(idx_r), .rdata(tag_rd));
  ohash_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(kv_we), .waddr(idx_r), .wdata(key_r),
    .raddr(idx_r), .rdata(key_rd));
  ohash_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(kv_we), .waddr(idx_r), .wdata(val_r),
    .raddr(idx_r), .rdata(val_rd));

  assign next_idx = (idx_r == AW'(CAPACITY - 1)) ? '0 : idx_r + 1'b1;
  assign last     = (n_r == NW'(CAPACITY - 1));
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_found_value = fv_r;
  assign out_slot_index = slot_r;
  assign out_live_count = cnt_r;
  assign out_collision_count = coll_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (idx_r == AW'(CAPACITY - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_H1;
      S_H1: state_nxt = S_H2;
      S_H2: state_nxt = S_H3;
      S_H3: state_nxt = S_H4;
      S_H4: state_nxt = S_H5;
      S_H5: state_nxt = S_H6;
      S_H6: state_nxt = S_H7;
      S_H7: state_nxt = S_HOME;
      S_HOME: begin
        if (cmd_r == CMD_NONE || (cmd_r == CMD_INSERT && cnt_r > limit_r)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_OUT;
        if (cmd_r == CMD_INSERT) begin
          if (tag_rd == TAG_LIVE && key_rd != key_r && !last) state_nxt = S_READ;
        end else if (tag_rd != TAG_EMPTY && !(tag_rd == TAG_LIVE && key_rd == key_r)
                     && !last) begin
          state_nxt = S_READ;
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tag_we = 1'b0;
    kv_we  = 1'b0;
    tag_wa = idx_r;
    tag_wd = TAG_EMPTY;
    unique case (state_r)
      S_CLEAR: tag_we = 1'b1;
      S_CHECK: begin
        if (cmd_r == CMD_INSERT && tag_rd != TAG_LIVE) begin
          tag_we = 1'b1;
          kv_we  = 1'b1;
          tag_wd = TAG_LIVE;
        end else if (cmd_r == CMD_REMOVE && tag_rd == TAG_LIVE && key_rd == key_r) begin
          tag_we = 1'b1;
          tag_wd = TAG_GONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      seed_r  <= SEED_RESET;
      limit_r <= LIMIT_RESET;
      cnt_r   <= '0;
      coll_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_SEED) seed_r <= cfg_data;
        else limit_r <= cfg_data[10:0];
      end
      case (state_r)
        S_CLEAR: idx_r <= next_idx;
        S_IDLE: begin
          step_r <= '0;
          if (in_valid) begin
            cmd_r <= in_command;
            key_r <= in_key;
            val_r <= in_value;
          end
        end
        S_HOME: begin
          idx_r  <= hash[AW-1:0];
          home_r <= hash[AW-1:0];
          n_r    <= '0;
          st_r   <= (cmd_r == CMD_INSERT) ? ST_FULL : ST_MISS;
          fv_r   <= '0;
          slot_r <= '0;
        end
        S_CHECK: begin
          if (cmd_r == CMD_INSERT) begin
            if (tag_rd != TAG_LIVE) begin
              st_r   <= ST_OK;
              slot_r <= 10'(idx_r);
              cnt_r  <= cnt_r + 1'b1;
              if (idx_r != home_r && coll_r != 32'hffffffff) coll_r <= coll_r + 1'b1;
            end else if (key_rd == key_r) begin
              st_r <= ST_DUP;
            end
          end else if (tag_rd == TAG_LIVE && key_rd == key_r) begin
            st_r   <= ST_OK;
            slot_r <= 10'(idx_r);
            if (cmd_r == CMD_LOOKUP) fv_r <= val_rd;
            else if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
          end
          if (state_nxt == S_READ) begin
            idx_r <= next_idx;
            n_r   <= n_r + 1'b1;
          end
        end
        default: if (step_r != 3'd7) step_r <= step_r + 1'b1;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_live_count))
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |-> tag_wd != 2'd3)
    else $error("invalid tag written");
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ohash_pkg::*;

  localparam int SLOTS = 1024;

  typedef struct {
    status_t            st;
    logic signed [63:0] fval;
    logic [9:0]         slot;
    logic [10:0]        live;
    logic [31:0]        coll;
  } answer_t;

  typedef struct {
    cmd_t               cmd;
    logic [63:0]        key;
    logic signed [63:0] val;
    bit                 fixed;
    status_t            st;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic [63:0] in_key;
  logic signed [63:0] in_value;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic signed [63:0] out_found_value;
  logic [9:0] out_slot_index;
  logic [10:0] out_live_count;
  logic [31:0] out_collision_count;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  open_addressing_hash_table dut (.*);

  tag_t               tbl_tag[SLOTS];
  logic [63:0]        tbl_key[SLOTS];
  logic signed [63:0] tbl_val[SLOTS];
  int unsigned        tbl_live;
  logic [31:0]        tbl_coll;
  logic [31:0]        seed;
  logic [10:0]        limit;

  answer_t pending[$];
  logic [63:0] placed_keys[$];
  int errors;
  bit quiet;
  bit took_result;
  int out_wait;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [31:0] murmur_round(logic [31:0] h, logic [31:0] k);
    k = k * C1;
    k = {k[16:0], k[31:17]};
    k = k * C2;
    h = h ^ k;
    h = {h[18:0], h[31:19]};
    return h * 32'd5 + C3;
  endfunction

  function automatic logic [9:0] home_slot(logic [63:0] key);
    logic [31:0] h;
    h = murmur_round(seed, key[31:0]);
    h = murmur_round(h, key[63:32]);
    h = h ^ 32'd8;
    h = h ^ (h >> 16);
    h = h * F1;
    h = h ^ (h >> 13);
    h = h * F2;
    h = h ^ (h >> 16);
    return h[9:0];
  endfunction

  function automatic answer_t table_step(cmd_t cmd, logic [63:0] key,
                                         logic signed [63:0] val);
    answer_t a;
    logic [9:0] home, idx;
    a.st = ST_MISS;
    a.fval = '0;
    a.slot = '0;
    home = home_slot(key);
    idx = home;
    if (cmd == CMD_INSERT) begin
      a.st = ST_FULL;
      if (tbl_live <= limit) begin
        for (int n = 0; n < SLOTS; n++) begin
          if (tbl_tag[idx] != TAG_LIVE) begin
            tbl_tag[idx] = TAG_LIVE;
            tbl_key[idx] = key;
            tbl_val[idx] = val;
            tbl_live++;
            if (idx != home && tbl_coll != 32'hffffffff) tbl_coll++;
            a.st = ST_OK;
            a.slot = idx;
            break;
          end
          if (tbl_key[idx] == key) begin
            a.st = ST_DUP;
            break;
          end
          idx++;
        end
      end
    end else if (cmd == CMD_LOOKUP || cmd == CMD_REMOVE) begin
      for (int n = 0; n < SLOTS; n++) begin
        if (tbl_tag[idx] == TAG_EMPTY) break;
        if (tbl_tag[idx] == TAG_LIVE && tbl_key[idx] == key) begin
          a.st = ST_OK;
          a.slot = idx;
          if (cmd == CMD_LOOKUP) begin
            a.fval = tbl_val[idx];
          end else begin
            tbl_tag[idx] = TAG_GONE;
            if (tbl_live > 0) tbl_live--;
          end
          break;
        end
        idx++;
      end
    end
    a.live = tbl_live[10:0];
    a.coll = tbl_coll;
    return a;
  endfunction

  task automatic issue(cmd_t cmd, logic [63:0] key, logic signed [63:0] val,
                       bit fixed = 0, status_t st = ST_OK);
    answer_t a;
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    a = table_step(cmd, key, val);
    if (fixed) a.st = st;
    pending.push_back(a);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SEED) seed = data;
    else limit = data[10:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && !out_stall) begin
      took_result = 1;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        a = pending.pop_front();
        if (out_status !== a.st) begin
          $error("status: expected %0d, got %0d", a.st, out_status);
          errors++;
        end
        if (out_found_value !== a.fval) begin
          $error("found_value: expected %0d, got %0d", a.fval, out_found_value);
          errors++;
        end
        if (out_slot_index !== a.slot) begin
          $error("slot_index: expected %0d, got %0d", a.slot, out_slot_index);
          errors++;
        end
        if (out_live_count !== a.live) begin
          $error("live_count: expected %0d, got %0d", a.live, out_live_count);
          errors++;
        end
        if (out_collision_count !== a.coll) begin
          $error("collision_count: expected %0d, got %0d", a.coll,
                 out_collision_count);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (took_result) begin
      took_result = 0;
      out_wait = quiet ? 0 : $urandom_range(0, 13);
    end
    out_stall <= (out_wait > 0);
    if (out_wait > 0) out_wait--;
  end

  localparam logic [63:0] KMAX = 64'hffffffffffffffff;
  localparam logic [63:0] KMAX1 = 64'hfffffffffffffffe;
  localparam logic signed [63:0] VMAX = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] VMIN = 64'sh8000000000000000;

  row_t script[] = '{
    '{CMD_LOOKUP, 64'd0, 64'sd0, 1, ST_MISS},
    '{CMD_REMOVE, 64'd0, 64'sd0, 1, ST_MISS},
    '{CMD_NONE, KMAX, VMIN, 1, ST_MISS},
    '{CMD_INSERT, 64'd0, VMAX, 1, ST_OK},
    '{CMD_INSERT, 64'd0, 64'sd5, 1, ST_DUP},
    '{CMD_INSERT, KMAX, VMIN, 1, ST_OK},
    '{CMD_INSERT, KMAX1, 64'sd1, 1, ST_OK},
    '{CMD_LOOKUP, KMAX, 64'sd0, 1, ST_OK},
    '{CMD_LOOKUP, KMAX1, VMAX, 1, ST_OK},
    '{CMD_LOOKUP, 64'd0, 64'sd0, 1, ST_OK},
    '{CMD_REMOVE, 64'd0, 64'sd0, 1, ST_OK},
    '{CMD_LOOKUP, 64'd0, 64'sd0, 1, ST_MISS},
    '{CMD_REMOVE, 64'd0, 64'sd0, 1, ST_MISS},
    '{CMD_INSERT, 64'd0, -64'sd1, 1, ST_OK},
    '{CMD_LOOKUP, 64'd0, 64'sd0, 0, ST_OK},
    '{CMD_INSERT, 64'h8000000000000000, 64'sd0, 0, ST_OK},
    '{CMD_INSERT, 64'd1, VMIN, 0, ST_OK},
    '{CMD_REMOVE, KMAX, 64'sd0, 0, ST_OK},
    '{CMD_INSERT, KMAX, 64'sd7, 0, ST_OK},
    '{CMD_NONE, 64'd0, VMAX, 1, ST_MISS},
    '{CMD_LOOKUP, 64'h5555aaaa5555aaaa, 64'sd0, 1, ST_MISS}
  };

  initial begin
    logic [63:0] pool[48];
    logic [63:0] k;
    int r;
    cmd_t c;
    errors = 0;
    quiet = 0;
    took_result = 0;
    out_wait = 0;
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_NONE;
    in_key = '0;
    in_value = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_SEED;
    cfg_data = '0;
    foreach (tbl_tag[i]) tbl_tag[i] = TAG_EMPTY;
    tbl_live = 0;
    tbl_coll = 0;
    seed = SEED_RESET;
    limit = LIMIT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (script[i])
      issue(script[i].cmd, script[i].key, script[i].val, script[i].fixed,
            script[i].st);

    write_reg(CFG_SEED, 32'd0);
    write_reg(CFG_LIMIT, 11'd0);
    for (int i = 0; i < 30; i++) begin
      k = (i % 2) ? KMAX : 64'(i % 4);
      issue(cmd_t'($urandom_range(0, 2)), k, {$urandom, $urandom});
    end

    write_reg(CFG_SEED, 32'hffffffff);
    write_reg(CFG_LIMIT, 11'd1024);
    quiet = 1;
    while (tbl_live < SLOTS) begin
      k = rand_key();
      placed_keys.push_back(k);
      issue(CMD_INSERT, k, {$urandom, $urandom});
    end
    quiet = 0;
    issue(CMD_INSERT, rand_key(), 64'sd3);
    issue(CMD_LOOKUP, rand_key(), 64'sd0);
    for (int i = 0; i < 20; i++)
      issue(CMD_LOOKUP, placed_keys[$urandom_range(0, placed_keys.size() - 1)], 0);
    for (int i = 0; i < placed_keys.size(); i += 10)
      issue(CMD_REMOVE, placed_keys[i], 64'sd0);

    write_reg(CFG_SEED, $urandom);
    write_reg(CFG_LIMIT, 11'd1000);
    foreach (pool[i]) pool[i] = (i < 2) ? KMAX - i : rand_key();
    for (int i = 0; i < 150; i++) begin
      quiet = ((i / 50) % 2) == 1;
      r = $urandom_range(0, 99);
      c = r < 45 ? CMD_INSERT : r < 72 ? CMD_LOOKUP : r < 95 ? CMD_REMOVE : CMD_NONE;
      k = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 47)] : rand_key();
      issue(c, k, {$urandom, $urandom});
    end
    in_valid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ohash_pkg.sv
rtl/ohash_ram.sv
rtl/ohash_hash.sv
rtl/open_addressing_hash_table.sv
dv/tb.sv
